// File: hdl/sacls_pkg.sv
package sacls_pkg;

    // fixed field widths
    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 62;
    localparam int CNT_W   = 32;
    localparam int OP_W    = 2;
    localparam int OC_W    = 2;
    localparam int CFG_W   = 6;
    localparam int CFG_A_W = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // outcomes
    localparam logic [OC_W-1:0] OC_HIT   = 2'd0;
    localparam logic [OC_W-1:0] OC_MISS  = 2'd1;
    localparam logic [OC_W-1:0] OC_EVICT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_SET_BITS  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_OFF_BITS  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_WAYS      = 2'd2;

    // sequencer states
    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOOK   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_UPDATE = 6'b010000,
        S_SECOND = 6'b100000
    } t_state;

endpackage

// File: hdl/set_assoc_lru_cache_classifier_core.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------------
// access    | in        | i_in_valid / o_in_ready    | i_address, i_opcode
// result    | out       | o_out_valid / i_out_ready  | o_outcome, o_*_total, o_last_*
// config    | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
// an access is taken in the idle state, then the set row and first tag are fetched, the
// ways are scanned one per cycle (a hit stops at its way) and the set is updated while the
// first result is posted. a modify then posts a second result. the single tag comparator
// walks the ways of the set one per cycle, reading one tag from the tag ram each cycle.
// after reset a clearing pass zeroes the valid/rank ram, one set per cycle, for all
// 2**MAX_SET_BITS sets, during which no access is taken.
// a result waiting on the output register stalls only the step that posts the next result.
module set_assoc_lru_cache_classifier_core #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sacls_pkg::CFG_A_W-1:0]       i_cfg_idx,
    input  logic [sacls_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sacls_pkg::ADDR_W-1:0]        i_address,
    input  logic [sacls_pkg::OP_W-1:0]          i_opcode,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sacls_pkg::OC_W-1:0]          o_outcome,
    output logic [sacls_pkg::CNT_W-1:0]         o_hit_total,
    output logic [sacls_pkg::CNT_W-1:0]         o_miss_total,
    output logic [sacls_pkg::CNT_W-1:0]         o_eviction_total,
    output logic                                o_last_of_access
);

    localparam int SW       = MAX_SET_BITS;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW       = $clog2(MAX_WAYS + 1);
    localparam int ROW_W    = MAX_WAYS * (WAY_W + 1);
    localparam int TAG_A_W  = SW + WAY_W;
    localparam int TAG_D    = 1 << TAG_A_W;
    localparam logic [WAY_W-1:0] RANK_MAX = WAY_W'(MAX_WAYS - 1);

    // configuration registers
    logic [2:0] r_cfg_set;
    logic [5:0] r_cfg_off;
    logic [3:0] r_cfg_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set  <= 3'd1;
            r_cfg_off  <= 6'd1;
            r_cfg_ways <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sacls_pkg::CFG_SET_BITS: r_cfg_set  <= i_cfg_wdata[2:0];
                sacls_pkg::CFG_OFF_BITS: r_cfg_off  <= i_cfg_wdata;
                sacls_pkg::CFG_WAYS:     r_cfg_ways <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [3:0]    eff_set;
    logic [5:0]    eff_off;
    logic [CW-1:0] eff_ways;

    always_comb begin
        eff_set = (r_cfg_set == 3'd0) ? 4'd1 : {1'b0, r_cfg_set};
        if (32'(eff_set) > MAX_SET_BITS) begin
            eff_set = 4'(MAX_SET_BITS);
        end
        eff_off = (r_cfg_off == 6'd0) ? 6'd1 : r_cfg_off;
        if (r_cfg_ways == 4'd0) begin
            eff_ways = CW'(1);
        end else if (32'(r_cfg_ways) > MAX_WAYS) begin
            eff_ways = CW'(MAX_WAYS);
        end else begin
            eff_ways = CW'(r_cfg_ways);
        end
    end

    // address split of the incoming access
    logic [sacls_pkg::ADDR_W-1:0] addr_sh;
    logic [SW-1:0]                set_keep;
    logic [SW-1:0]                in_set;
    logic [6:0]                   tag_sh;
    logic [sacls_pkg::TAG_W-1:0]  in_tag;

    always_comb begin
        addr_sh = i_address >> eff_off;
        for (int k = 0; k < SW; k++) begin
            set_keep[k] = (32'(k) < 32'(eff_set));
        end
        in_set = addr_sh[SW-1:0] & set_keep;
        tag_sh = 7'(eff_set) + 7'(eff_off);
        in_tag = (tag_sh >= 7'd64) ? '0 : sacls_pkg::TAG_W'(i_address >> tag_sh);
    end

    // state and work registers
    sacls_pkg::t_state r_state, n_state;
    logic [SW-1:0]                r_clr, n_clr;
    logic [SW-1:0]                r_set, n_set;
    logic [sacls_pkg::TAG_W-1:0]  r_tag, n_tag;
    logic                         r_modify, n_modify;
    logic [WAY_W-1:0]             r_way, n_way;
    logic                         r_free_found, n_free_found;
    logic [WAY_W-1:0]             r_free_way, n_free_way;
    logic [WAY_W-1:0]             r_vic_way, n_vic_way;
    logic [WAY_W-1:0]             r_vic_rank, n_vic_rank;
    logic [WAY_W-1:0]             r_tgt, n_tgt;
    logic [sacls_pkg::OC_W-1:0]   r_oc, n_oc;
    logic [sacls_pkg::CNT_W-1:0]  r_hits, n_hits;
    logic [sacls_pkg::CNT_W-1:0]  r_misses, n_misses;
    logic [sacls_pkg::CNT_W-1:0]  r_evicts, n_evicts;
    logic                         r_out_valid, n_out_valid;
    logic [sacls_pkg::OC_W-1:0]   r_out_oc, n_out_oc;
    logic                         r_out_last, n_out_last;

    // memory ports
    logic                         row_we, row_re;
    logic [SW-1:0]                row_waddr;
    logic [ROW_W-1:0]             row_wdata, row_rdata;
    logic                         tag_we, tag_re;
    logic [TAG_A_W-1:0]           tag_waddr, tag_raddr;
    logic [sacls_pkg::TAG_W-1:0]  tag_rdata;

    sacls_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (r_set),
        .o_rdata (row_rdata)
    );

    sacls_ram #(
        .WIDTH (sacls_pkg::TAG_W),
        .DEPTH (TAG_D)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_tag),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    // unpack the valid bits and recency ranks of the set
    logic [MAX_WAYS-1:0] row_valid;
    logic [WAY_W-1:0]    row_rank [MAX_WAYS];

    always_comb begin
        row_valid = row_rdata[MAX_WAYS-1:0];
        for (int k = 0; k < MAX_WAYS; k++) begin
            row_rank[k] = row_rdata[MAX_WAYS + k*WAY_W +: WAY_W];
        end
    end

    // recency update: target becomes most recent, younger valid ways age
    logic [WAY_W-1:0] old_rank;
    logic             fresh;
    logic [ROW_W-1:0] row_touched;

    always_comb begin
        old_rank    = row_rank[r_tgt];
        fresh       = (r_oc == sacls_pkg::OC_MISS);
        row_touched = row_rdata;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (WAY_W'(k) == r_tgt) begin
                row_touched[k]                      = 1'b1;
                row_touched[MAX_WAYS + k*WAY_W +: WAY_W] = '0;
            end else if ((CW'(k) < eff_ways) && row_valid[k]
                         && (fresh || (row_rank[k] < old_rank))
                         && (row_rank[k] < RANK_MAX)) begin
                row_touched[MAX_WAYS + k*WAY_W +: WAY_W] = row_rank[k] + WAY_W'(1);
            end
        end
    end

    // one way of the scan per cycle
    logic             way_valid;
    logic [WAY_W-1:0] way_rank;
    logic             way_match;
    logic             way_last;
    logic             out_xfer;
    logic             out_free;

    assign way_valid = row_valid[r_way];
    assign way_rank  = row_rank[r_way];
    assign way_match = way_valid && (tag_rdata == r_tag);
    assign way_last  = ((CW'(r_way) + CW'(1)) == eff_ways);
    assign out_xfer  = r_out_valid && i_out_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_set        = r_set;
        n_tag        = r_tag;
        n_modify     = r_modify;
        n_way        = r_way;
        n_free_found = r_free_found;
        n_free_way   = r_free_way;
        n_vic_way    = r_vic_way;
        n_vic_rank   = r_vic_rank;
        n_tgt        = r_tgt;
        n_oc         = r_oc;
        n_hits       = r_hits;
        n_misses     = r_misses;
        n_evicts     = r_evicts;
        n_out_valid  = r_out_valid && !out_xfer;
        n_out_oc     = r_out_oc;
        n_out_last   = r_out_last;
        row_we       = 1'b0;
        row_re       = 1'b0;
        row_waddr    = r_set;
        row_wdata    = row_touched;
        tag_we       = 1'b0;
        tag_re       = 1'b0;
        tag_waddr    = {r_set, r_tgt};
        tag_raddr    = {r_set, r_way + WAY_W'(1)};
        o_in_ready   = 1'b0;

        unique case (r_state)
            sacls_pkg::S_CLEAR: begin
                // zero valid bits and ranks, one set per cycle
                row_we    = 1'b1;
                row_waddr = r_clr;
                row_wdata = '0;
                n_clr     = r_clr + SW'(1);
                if (r_clr == SW'(NUM_SETS - 1)) begin
                    n_state = sacls_pkg::S_IDLE;
                end
            end
            sacls_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_set    = in_set;
                    n_tag    = in_tag;
                    n_modify = (i_opcode == sacls_pkg::OP_MODIFY);
                    n_state  = sacls_pkg::S_LOOK;
                end
            end
            sacls_pkg::S_LOOK: begin
                // fetch the set row and the first tag
                row_re       = 1'b1;
                tag_re       = 1'b1;
                tag_raddr    = {r_set, WAY_W'(0)};
                n_way        = '0;
                n_free_found = 1'b0;
                n_state      = sacls_pkg::S_SCAN;
            end
            sacls_pkg::S_SCAN: begin
                if (way_match) begin
                    n_tgt   = r_way;
                    n_oc    = sacls_pkg::OC_HIT;
                    n_state = sacls_pkg::S_UPDATE;
                end else begin
                    if (!r_free_found && !way_valid) begin
                        n_free_found = 1'b1;
                        n_free_way   = r_way;
                    end
                    if ((r_way == '0) || (way_rank > r_vic_rank)) begin
                        n_vic_way  = r_way;
                        n_vic_rank = way_rank;
                    end
                    if (way_last) begin
                        n_tgt   = n_free_found ? n_free_way : n_vic_way;
                        n_oc    = n_free_found ? sacls_pkg::OC_MISS : sacls_pkg::OC_EVICT;
                        n_state = sacls_pkg::S_UPDATE;
                    end else begin
                        tag_re = 1'b1;
                        n_way  = r_way + WAY_W'(1);
                    end
                end
            end
            sacls_pkg::S_UPDATE: begin
                // write back the set and post the result once the output is free
                if (out_free) begin
                    row_we      = 1'b1;
                    tag_we      = (r_oc != sacls_pkg::OC_HIT);
                    n_out_valid = 1'b1;
                    n_out_oc    = r_oc;
                    n_out_last  = !r_modify;
                    case (r_oc)
                        sacls_pkg::OC_HIT: n_hits = r_hits + 32'd1;
                        sacls_pkg::OC_MISS: n_misses = r_misses + 32'd1;
                        default: begin
                            n_misses = r_misses + 32'd1;
                            n_evicts = r_evicts + 32'd1;
                        end
                    endcase
                    n_state = r_modify ? sacls_pkg::S_SECOND : sacls_pkg::S_IDLE;
                end
            end
            sacls_pkg::S_SECOND: begin
                // second lookup of a modify always hits the way just touched
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_oc    = sacls_pkg::OC_HIT;
                    n_out_last  = 1'b1;
                    n_hits      = r_hits + 32'd1;
                    n_state     = sacls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sacls_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sacls_pkg::S_CLEAR;
            r_clr       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_evicts    <= n_evicts;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_set        <= n_set;
        r_tag        <= n_tag;
        r_modify     <= n_modify;
        r_way        <= n_way;
        r_free_found <= n_free_found;
        r_free_way   <= n_free_way;
        r_vic_way    <= n_vic_way;
        r_vic_rank   <= n_vic_rank;
        r_tgt        <= n_tgt;
        r_oc         <= n_oc;
        r_out_oc     <= n_out_oc;
        r_out_last   <= n_out_last;
    end

    // outputs; counters only move when a result is posted
    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_out_oc;
    assign o_last_of_access = r_out_last;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;

`ifndef ASSERT_OFF
    // scan never walks past the ways in use
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sacls_pkg::S_SCAN) |-> (CW'(r_way) < eff_ways))
        else $error("scan past ways in use");

    // counters move only when a result is posted
    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sacls_pkg::S_UPDATE && r_state != sacls_pkg::S_SECOND)
        |=> ($stable(r_hits) && $stable(r_misses) && $stable(r_evicts)))
        else $error("counter moved outside update");

    // every eviction is also counted as a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_evicts)) |-> !$stable(r_misses))
        else $error("eviction without miss");

    // a non-final result belongs to a modify access
    a_first_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_modify)
        else $error("non-final result outside modify");
`endif

endmodule

// File: hdl/sacls_ram.sv
module sacls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/sv/set_assoc_lru_cache_classifier_checker.sv
`timescale 1ns / 1ps

module set_assoc_lru_cache_classifier_checker #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sacls_pkg::CFG_A_W-1:0]       i_cfg_idx,
    input  logic [sacls_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [sacls_pkg::ADDR_W-1:0]        i_address,
    input  logic [sacls_pkg::OP_W-1:0]          i_opcode,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [sacls_pkg::OC_W-1:0]          i_outcome,
    input  logic [sacls_pkg::CNT_W-1:0]         i_hit_total,
    input  logic [sacls_pkg::CNT_W-1:0]         i_miss_total,
    input  logic [sacls_pkg::CNT_W-1:0]         i_eviction_total,
    input  logic                                i_last_of_access,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_hits_seen,
    output int                                  o_evictions_seen
);

    localparam int NUM_LINES   = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int RANK_OLDEST = MAX_WAYS - 1;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [sacls_pkg::OC_W-1:0]  outcome;
        logic [sacls_pkg::CNT_W-1:0] hits;
        logic [sacls_pkg::CNT_W-1:0] misses;
        logic [sacls_pkg::CNT_W-1:0] evictions;
        logic                        last;
    } t_lookup_result;

    // shadow copy of the cache shape registers
    logic [2:0] set_bits_reg;
    logic [5:0] off_bits_reg;
    logic [3:0] ways_reg;

    // shadow copy of the tag store and its recency order
    logic [sacls_pkg::TAG_W-1:0] tag_ram [NUM_LINES];
    bit                          line_ok [NUM_LINES];
    int unsigned                 rank_ram [NUM_LINES];
    logic [sacls_pkg::CNT_W-1:0] hit_cnt;
    logic [sacls_pkg::CNT_W-1:0] miss_cnt;
    logic [sacls_pkg::CNT_W-1:0] evict_cnt;

    t_lookup_result   expected_lookups [$];
    int               fail_cnt;
    int               result_cnt;
    int               hit_seen_cnt;
    int               evict_seen_cnt;

    function automatic int unsigned active_set_bits();
        int unsigned s;
        s = set_bits_reg;
        if (s < 1) s = 1;
        if (s > MAX_SET_BITS) s = MAX_SET_BITS;
        return s;
    endfunction

    function automatic int unsigned active_off_bits();
        int unsigned b;
        b = off_bits_reg;
        if (b < 1) b = 1;
        return b;
    endfunction

    function automatic int unsigned active_ways();
        int unsigned w;
        w = ways_reg;
        if (w < 1) w = 1;
        if (w > MAX_WAYS) w = MAX_WAYS;
        return w;
    endfunction

    // move one way to most recent; younger valid ways age by one, saturating
    function automatic void promote_way(int unsigned base, int unsigned ways,
                                        int unsigned way, bit fresh_fill);
        int unsigned old_rank;
        old_rank = fresh_fill ? MAX_WAYS : rank_ram[base + way];
        for (int unsigned i = 0; i < ways; i++) begin
            if (i != way && line_ok[base + i] && rank_ram[base + i] < old_rank
                    && rank_ram[base + i] < RANK_OLDEST)
                rank_ram[base + i] = rank_ram[base + i] + 1;
        end
        rank_ram[base + way] = 0;
    endfunction

    // one cache lookup: classify, update lines, ranks and counters
    function automatic logic [sacls_pkg::OC_W-1:0] classify_access(
            logic [sacls_pkg::ADDR_W-1:0] addr);
        int unsigned                 s;
        int unsigned                 b;
        int unsigned                 ways;
        int unsigned                 set_idx;
        int unsigned                 base;
        int unsigned                 victim;
        logic [sacls_pkg::TAG_W-1:0] tag;
        s       = active_set_bits();
        b       = active_off_bits();
        ways    = active_ways();
        set_idx = int'((addr >> b) & ((64'd1 << s) - 64'd1));
        tag     = (s + b >= sacls_pkg::ADDR_W) ? '0 : sacls_pkg::TAG_W'(addr >> (s + b));
        base    = set_idx * MAX_WAYS;
        for (int unsigned i = 0; i < ways; i++) begin
            if (line_ok[base + i] && tag_ram[base + i] == tag) begin
                promote_way(base, ways, i, 1'b0);
                hit_cnt = hit_cnt + 1'b1;
                return sacls_pkg::OC_HIT;
            end
        end
        miss_cnt = miss_cnt + 1'b1;
        for (int unsigned i = 0; i < ways; i++) begin
            if (!line_ok[base + i]) begin
                promote_way(base, ways, i, 1'b1);
                line_ok[base + i] = 1'b1;
                tag_ram[base + i] = tag;
                return sacls_pkg::OC_MISS;
            end
        end
        // full set: oldest in-use way, lowest number on a tie
        victim = 0;
        for (int unsigned i = 1; i < ways; i++) begin
            if (rank_ram[base + i] > rank_ram[base + victim]) victim = i;
        end
        promote_way(base, ways, victim, 1'b0);
        tag_ram[base + victim] = tag;
        evict_cnt = evict_cnt + 1'b1;
        return sacls_pkg::OC_EVICT;
    endfunction

    task automatic report_mismatch(input string what);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $time, result_cnt, what);
    endtask

    // watch the three ports, compare results, then predict new accesses
    always @(posedge i_clk) begin : monitor
        t_lookup_result got;
        t_lookup_result want;
        int unsigned    n_lookups;
        if (!i_rst_n) begin
            set_bits_reg = 3'd1;
            off_bits_reg = 6'd1;
            ways_reg     = 4'd1;
            for (int i = 0; i < NUM_LINES; i++) begin
                line_ok[i]  = 1'b0;
                rank_ram[i] = 0;
            end
            hit_cnt   = '0;
            miss_cnt  = '0;
            evict_cnt = '0;
            expected_lookups.delete();
            fail_cnt       = 0;
            result_cnt     = 0;
            hit_seen_cnt   = 0;
            evict_seen_cnt = 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sacls_pkg::CFG_SET_BITS: set_bits_reg = i_cfg_wdata[2:0];
                    sacls_pkg::CFG_OFF_BITS: off_bits_reg = i_cfg_wdata[5:0];
                    sacls_pkg::CFG_WAYS:     ways_reg     = i_cfg_wdata[3:0];
                    default: ;
                endcase
            end

            // result transfer
            if (i_out_valid && i_out_ready) begin
                result_cnt++;
                got.outcome   = i_outcome;
                got.hits      = i_hit_total;
                got.misses    = i_miss_total;
                got.evictions = i_eviction_total;
                got.last      = i_last_of_access;
                if (got.outcome == sacls_pkg::OC_HIT) hit_seen_cnt++;
                if (got.outcome == sacls_pkg::OC_EVICT) evict_seen_cnt++;
                if (expected_lookups.size() == 0) begin
                    report_mismatch($sformatf("result with no access pending (outcome %0d)",
                                              got.outcome));
                end else begin
                    want = expected_lookups.pop_front();
                    if (got.outcome !== want.outcome)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  got.outcome, want.outcome));
                    if (got.hits !== want.hits)
                        report_mismatch($sformatf("hit_total %0d, expected %0d",
                                                  got.hits, want.hits));
                    if (got.misses !== want.misses)
                        report_mismatch($sformatf("miss_total %0d, expected %0d",
                                                  got.misses, want.misses));
                    if (got.evictions !== want.evictions)
                        report_mismatch($sformatf("eviction_total %0d, expected %0d",
                                                  got.evictions, want.evictions));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_of_access %0b, expected %0b",
                                                  got.last, want.last));
                end
            end

            // access transfer: a modify looks up twice
            if (i_in_valid && i_in_ready) begin
                n_lookups = (i_opcode == sacls_pkg::OP_MODIFY) ? 2 : 1;
                for (int unsigned k = 0; k < n_lookups; k++) begin
                    want.outcome   = classify_access(i_address);
                    want.hits      = hit_cnt;
                    want.misses    = miss_cnt;
                    want.evictions = evict_cnt;
                    want.last      = (k == n_lookups - 1);
                    expected_lookups.push_back(want);
                end
            end
        end
        o_fail_count     <= fail_cnt;
        o_pending        <= expected_lookups.size();
        o_checked        <= result_cnt;
        o_hits_seen      <= hit_seen_cnt;
        o_evictions_seen <= evict_seen_cnt;
    end

endmodule

// File: tb/sv/set_assoc_lru_cache_classifier_core_tb.sv
`timescale 1ns / 1ps

module set_assoc_lru_cache_classifier_core_tb;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    // opcode 3 has no name in the package; the block treats it as a load
    localparam logic [sacls_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 24;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [sacls_pkg::CFG_A_W-1:0]   i_cfg_idx   = sacls_pkg::CFG_SET_BITS;
    logic [sacls_pkg::CFG_W-1:0]     i_cfg_wdata = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    logic [sacls_pkg::ADDR_W-1:0]    i_address   = '0;
    logic [sacls_pkg::OP_W-1:0]      i_opcode    = sacls_pkg::OP_LOAD;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [sacls_pkg::OC_W-1:0]      o_outcome;
    logic [sacls_pkg::CNT_W-1:0]     o_hit_total;
    logic [sacls_pkg::CNT_W-1:0]     o_miss_total;
    logic [sacls_pkg::CNT_W-1:0]     o_eviction_total;
    logic                            o_last_of_access;

    int                   fail_count;
    int                   pending_lookups;
    int                   results_checked;
    int                   hits_seen;
    int                   evictions_seen;

    // stimulus bookkeeping
    int unsigned                  cycle_count    = 0;
    int unsigned                  accesses_sent  = 0;
    int unsigned                  shapes_applied = 0;
    bit                           quiet          = 1'b0;
    bit                           hold_request   = 1'b0;
    int unsigned                  cur_set_bits   = 1;
    int unsigned                  cur_off_bits   = 1;
    int unsigned                  cur_ways       = 1;
    logic [sacls_pkg::ADDR_W-1:0] tag_salt       = '0;

    set_assoc_lru_cache_classifier_core #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_address        (i_address),
        .i_opcode         (i_opcode),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total),
        .o_last_of_access (o_last_of_access)
    );

    set_assoc_lru_cache_classifier_checker #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_address        (i_address),
        .i_opcode         (i_opcode),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_outcome        (o_outcome),
        .i_hit_total      (o_hit_total),
        .i_miss_total     (o_miss_total),
        .i_eviction_total (o_eviction_total),
        .i_last_of_access (o_last_of_access),
        .o_fail_count     (fail_count),
        .o_pending        (pending_lookups),
        .o_checked        (results_checked),
        .o_hits_seen      (hits_seen),
        .o_evictions_seen (evictions_seen)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d lookups outstanding",
                     cycle_count, pending_lookups);
            $display("set_assoc_lru_cache_classifier_core_tb failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 7);
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // offer one access and hold it until the transfer
    task automatic send_access(input logic [sacls_pkg::ADDR_W-1:0] addr,
                               input logic [sacls_pkg::OP_W-1:0] op);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        i_opcode   <= op;
        do @(posedge i_clk); while (!o_in_ready);
        accesses_sent++;
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_lookups != 0);
    endtask

    // write all three shape registers while the block is idle
    task automatic apply_shape(input logic [sacls_pkg::CFG_W-1:0] idx_bits,
                               input logic [sacls_pkg::CFG_W-1:0] off_bits,
                               input logic [sacls_pkg::CFG_W-1:0] ways);
        wait_all_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= sacls_pkg::CFG_SET_BITS;
        i_cfg_wdata <= idx_bits;
        @(posedge i_clk);
        i_cfg_idx   <= sacls_pkg::CFG_OFF_BITS;
        i_cfg_wdata <= off_bits;
        @(posedge i_clk);
        i_cfg_idx   <= sacls_pkg::CFG_WAYS;
        i_cfg_wdata <= ways;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        // effective shape, used only to aim addresses at a few sets and tags
        cur_set_bits = idx_bits & 7;
        if (cur_set_bits < 1) cur_set_bits = 1;
        if (cur_set_bits > MAX_SET_BITS) cur_set_bits = MAX_SET_BITS;
        cur_off_bits = off_bits;
        if (cur_off_bits < 1) cur_off_bits = 1;
        cur_ways = ways & 15;
        if (cur_ways < 1) cur_ways = 1;
        if (cur_ways > MAX_WAYS) cur_ways = MAX_WAYS;
        tag_salt = {$urandom, $urandom};
        shapes_applied++;
    endtask

    // mostly a few sets and a small tag pool so that lines get reused
    function automatic logic [sacls_pkg::ADDR_W-1:0] pick_address();
        logic [sacls_pkg::ADDR_W-1:0] addr;
        logic [sacls_pkg::ADDR_W-1:0] tag;
        int unsigned                  set_idx;
        addr = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) return addr;
        if ($urandom_range(0, 4) != 0) set_idx = $urandom_range(0, 3);
        else set_idx = $urandom_range(0, 63);
        set_idx = set_idx & ((1 << cur_set_bits) - 1);
        tag = sacls_pkg::ADDR_W'($urandom_range(0, cur_ways + 2));
        if ($urandom_range(0, 3) == 0) tag = tag ^ tag_salt;
        addr = addr & ((64'd1 << cur_off_bits) - 64'd1);
        addr = addr | (sacls_pkg::ADDR_W'(set_idx) << cur_off_bits);
        if (cur_set_bits + cur_off_bits < sacls_pkg::ADDR_W)
            addr = addr | (tag << (cur_set_bits + cur_off_bits));
        return addr;
    endfunction

    task automatic random_accesses(input int unsigned count);
        logic [sacls_pkg::OP_W-1:0] op;
        for (int unsigned n = 0; n < count; n++) begin
            op = sacls_pkg::OP_W'($urandom_range(0, 3));
            send_access(pick_address(), op);
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 4 sets, 16-byte blocks, 2 ways: tag starts at bit 6
        apply_shape(6'd2, 6'd4, 6'd2);
        send_access(64'h0, sacls_pkg::OP_LOAD);
        send_access(64'h5, sacls_pkg::OP_STORE);
        send_access(64'h0, sacls_pkg::OP_MODIFY);
        send_access(64'h40, sacls_pkg::OP_LOAD);
        send_access(64'h80, sacls_pkg::OP_MODIFY);
        send_access(64'h0, OP_RESERVED);
        send_access(64'h40, sacls_pkg::OP_STORE);
        send_access('1, sacls_pkg::OP_LOAD);
        send_access('1, sacls_pkg::OP_MODIFY);
        send_access(64'hFFFF_FFFF_FFFF_FFC0, sacls_pkg::OP_STORE);
        send_access(64'h8000_0000_0000_0000, sacls_pkg::OP_LOAD);
        send_access(64'h30, OP_RESERVED);
        send_access(64'h30, sacls_pkg::OP_MODIFY);

        // all-zero registers fall back to the smallest shape
        apply_shape(6'd0, 6'd0, 6'd0);
        send_access(64'h0, sacls_pkg::OP_LOAD);
        send_access(64'h4, sacls_pkg::OP_MODIFY);
        random_accesses(95);

        // set and offset past 64 bits: every tag reads as zero
        apply_shape(6'd6, 6'd63, 6'd8);
        send_access(64'h0, sacls_pkg::OP_LOAD);
        send_access(64'h8000_0000_0000_0000, sacls_pkg::OP_MODIFY);
        send_access(64'h7FFF_FFFF_FFFF_FFFF, sacls_pkg::OP_STORE);
        random_accesses(85);

        // long result hold-off so the block backs up into its input
        apply_shape(6'd3, 6'd5, 6'd4);
        hold_request = 1'b1;
        random_accesses(110);

        // oversized set and way counts clamp to the maximum
        apply_shape(6'd7, 6'd10, 6'd15);
        random_accesses(100);

        apply_shape(6'd1, 6'd1, 6'd8);
        random_accesses(100);

        // upper data bits beyond each register width are dropped
        apply_shape(6'd13, 6'd6, 6'd20);
        random_accesses(100);

        // fewer ways while lines stay held in the upper ways
        apply_shape(6'd2, 6'd3, 6'd2);
        random_accesses(100);

        apply_shape(6'd5, 6'd32, 6'd3);
        random_accesses(100);

        // back-to-back stretch with no stalls on either side
        apply_shape(6'd4, 6'd2, 6'd8);
        quiet = 1'b1;
        random_accesses(130);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d accesses over %0d cache shapes, incl. zero, clamped and tag-free ones",
                 accesses_sent, shapes_applied);
        $display("%0d results checked: %0d hits, %0d evictions, %0d mismatches",
                 results_checked, hits_seen, evictions_seen, fail_count);
        if (fail_count == 0) begin
            $display("set_assoc_lru_cache_classifier_core_tb passed");
        end else begin
            $display("set_assoc_lru_cache_classifier_core_tb failed");
        end
        $finish;
    end

endmodule
